### hw/rtl/spisd_pkg.sv
// shared types and constants of the spi bus sniffer decoder
`default_nettype none

package spisd_pkg;

  localparam int INDEX_BITS    = 32;
  localparam int PENDING_DEPTH = 8;
  localparam int MAX_WORD_BITS = 8;
  localparam int MIN_SPAN      = 15;
  localparam int OUT_W         = 32;
  localparam int EVQ_DEPTH     = 2;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CLK_POL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLK_PHA   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MSB_FIRST = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_BITS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SEL_MODE  = 3'd4;

  // chip select modes
  localparam logic [1:0] SEL_NONE = 2'd0;
  localparam logic [1:0] SEL_LOW  = 2'd1;
  localparam logic [1:0] SEL_HIGH = 2'd2;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_CLK_ERR = 2'd1,
    KIND_SHORT   = 2'd2
  } kind_e;

  typedef struct packed {
    logic chip_select;
    logic sclk;
    logic mosi;
    logic miso;
    logic capture_end;
  } smp_t;

  typedef struct packed {
    logic [1:0]                 record_kind;
    logic [MAX_WORD_BITS-1:0]   mosi_word;
    logic [MAX_WORD_BITS-1:0]   miso_word;
    logic [OUT_W-1:0]           start_sample;
    logic [OUT_W-1:0]           span_samples;
    logic                       last_of_run;
  } res_t;

  typedef struct packed {
    logic [MAX_WORD_BITS-1:0] mosi;
    logic [MAX_WORD_BITS-1:0] miso;
    logic [OUT_W-1:0]         start;
    logic [OUT_W-1:0]         span;
  } word_t;

  typedef struct packed {
    kind_e kind;
    word_t w;
  } rec_t;

  // everything one sample causes, in emission order
  typedef struct packed {
    logic pre_v;
    rec_t pre;
    logic flush;
    logic wd_v;
    logic wd_early;
    rec_t wd;
    logic fin_v;
    rec_t fin;
    logic clr;
  } event_t;

endpackage

`default_nettype wire

### hw/rtl/spi_bus_sniffer_decoder_core.sv
// top level of the spi bus sniffer decoder
//
//   channel   direction  handshake              beat
//   samples   in         push / full            smp_i (select, clock, mosi, miso, end mark)
//   records   out        pop / empty            res_o (kind, words, start, span, last)
//   config    in         cfg_valid / cfg_ready  cfg_index_i, cfg_data_i
//
// one sample beat is taken per cycle while full is low; the front end updates frame state in that cycle
// and queues everything the sample causes for the back end.
// records leave one per cycle through the output register while pop keeps it free;
// a sample that frees held words keeps the back end busy as the registered held list reads them.
// reset clears all control state; the held word list needs no clearing pass.
// full rises when the two-entry event queue fills: pop held low, or samples arriving
// while one sample's records are still leaving.
`default_nettype none

module spi_bus_sniffer_decoder_core #(
  parameter int IndexBits = spisd_pkg::INDEX_BITS,
  parameter int PendDepth = spisd_pkg::PENDING_DEPTH
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             push,
  input  wire spisd_pkg::smp_t                  smp_i,
  output logic                                  full,
  input  wire logic                             pop,
  output spisd_pkg::res_t                       res_o,
  output logic                                  empty,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [spisd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [spisd_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  spisd_pkg::event_t ev_in, ev_out;
  logic              accept, ev_empty, ev_pop;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  spisd_front #(
    .IndexBits (IndexBits)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .smp_i       (smp_i),
    .ev_o        (ev_in)
  );

  spisd_evq u_evq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (ev_in),
    .full_o  (full),
    .pop_i   (ev_pop),
    .data_o  (ev_out),
    .empty_o (ev_empty)
  );

  spisd_back #(
    .PendDepth (PendDepth)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ev_empty_i (ev_empty),
    .ev_i       (ev_out),
    .ev_pop_o   (ev_pop),
    .res_o      (res_o),
    .empty      (empty),
    .pop        (pop)
  );

endmodule

`default_nettype wire

### hw/rtl/spisd_ram.sv
// generic single write port ram with registered read
`default_nettype none

module spisd_ram #(
  parameter int Width = 80,
  parameter int Depth = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/spisd_front.sv
// front end: frame tracking, edge detection and word assembly per sample
`default_nettype none

module spisd_front #(
  parameter int IndexBits = spisd_pkg::INDEX_BITS
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  input  wire logic [spisd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [spisd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                             accept_i,
  input  wire spisd_pkg::smp_t                  smp_i,
  output spisd_pkg::event_t                     ev_o
);

  localparam int OutW = spisd_pkg::OUT_W;
  localparam int WordW = spisd_pkg::MAX_WORD_BITS;

  // configuration
  logic       pol_q, pha_q, msb_q;
  logic [3:0] wbits_q;
  logic [1:0] sel_q;

  // decoder state
  logic [IndexBits-1:0] cnt_q, cnt_d;
  logic [IndexBits-1:0] fstart_q, fstart_d;
  logic [IndexBits-1:0] first_q, first_d;
  logic [IndexBits-1:0] second_q, second_d;
  logic [IndexBits-1:0] lastp_q, lastp_d;
  logic                 prev_q, prev_d;
  logic                 infr_q, infr_d;
  logic                 ok_q, ok_d;
  logic                 long_q, long_d;
  logic [WordW-1:0]     mo_q, mo_d, mi_q, mi_d;
  logic [3:0]           bc_q, bc_d;

  logic                 act, target, pre_close, open_f, cont, edge_f;
  logic [3:0]           eff, bc_inc;
  logic [WordW-1:0]     mo_base, mi_base;
  logic [IndexBits-1:0] n;

  function automatic spisd_pkg::rec_t close_rec(input logic                 ok,
                                                input logic [IndexBits-1:0] fs,
                                                input logic [IndexBits-1:0] sec,
                                                input logic [IndexBits-1:0] lst,
                                                input logic [IndexBits-1:0] stop);
    spisd_pkg::rec_t r;
    r = '0;
    if (!ok) begin
      r.kind    = spisd_pkg::KIND_CLK_ERR;
      r.w.start = OutW'(fs);
      r.w.span  = OutW'(stop - fs);
    end else begin
      r.kind    = spisd_pkg::KIND_SHORT;
      r.w.start = OutW'(sec - IndexBits'(1));
      r.w.span  = OutW'(lst - sec + IndexBits'(2));
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pol_q   <= 1'b0;
      pha_q   <= 1'b0;
      msb_q   <= 1'b1;
      wbits_q <= 4'd8;
      sel_q   <= spisd_pkg::SEL_LOW;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        spisd_pkg::CFG_CLK_POL:   pol_q   <= cfg_data_i[0];
        spisd_pkg::CFG_CLK_PHA:   pha_q   <= cfg_data_i[0];
        spisd_pkg::CFG_MSB_FIRST: msb_q   <= cfg_data_i[0];
        spisd_pkg::CFG_WORD_BITS: wbits_q <= cfg_data_i[3:0];
        spisd_pkg::CFG_SEL_MODE:  sel_q   <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel_q)
      spisd_pkg::SEL_LOW:  act = !smp_i.chip_select;
      spisd_pkg::SEL_HIGH: act = smp_i.chip_select;
      default:             act = 1'b1;
    endcase
  end

  always_comb begin
    priority if (wbits_q == 4'd0) begin
      eff = 4'd1;
    end else if (wbits_q > 4'(WordW)) begin
      eff = 4'(WordW);
    end else begin
      eff = wbits_q;
    end
  end

  assign n         = cnt_q;
  assign target    = !(pha_q ^ pol_q);
  assign pre_close = infr_q && !act;
  assign open_f    = !infr_q && act;
  assign cont      = infr_q && act;
  assign edge_f    = cont && ok_q && (smp_i.sclk == target) && (prev_q != target);
  assign bc_inc    = bc_q + 4'd1;
  assign mo_base   = (bc_q == 4'd0) ? '0 : mo_q;
  assign mi_base   = (bc_q == 4'd0) ? '0 : mi_q;

  always_comb begin
    ev_o     = '0;
    fstart_d = fstart_q;
    first_d  = first_q;
    second_d = second_q;
    lastp_d  = lastp_q;
    infr_d   = infr_q;
    ok_d     = ok_q;
    long_d   = long_q;
    mo_d     = mo_q;
    mi_d     = mi_q;
    bc_d     = bc_q;
    prev_d   = smp_i.sclk;

    if (pre_close) begin
      ev_o.pre_v = long_q && (!ok_q || (bc_q >= 4'd2 && bc_q < eff));
      ev_o.pre   = close_rec(ok_q, fstart_q, second_q, lastp_q, n - IndexBits'(1));
      infr_d     = 1'b0;
    end

    if (open_f) begin
      infr_d   = 1'b1;
      fstart_d = n;
      ok_d     = (smp_i.sclk == pol_q);
      long_d   = 1'b0;
      bc_d     = '0;
      mo_d     = '0;
      mi_d     = '0;
    end

    if (cont) begin
      if (!long_q && (n - fstart_q) == IndexBits'(spisd_pkg::MIN_SPAN + 1)) begin
        long_d     = 1'b1;
        ev_o.flush = 1'b1;
      end
      if (edge_f) begin
        if (bc_q == 4'd0) begin
          first_d = n;
        end
        if (msb_q) begin
          mo_d = {mo_base[WordW-2:0], smp_i.mosi};
          mi_d = {mi_base[WordW-2:0], smp_i.miso};
        end else begin
          mo_d = mo_base | (WordW'(smp_i.mosi) << bc_q[2:0]);
          mi_d = mi_base | (WordW'(smp_i.miso) << bc_q[2:0]);
        end
        bc_d = bc_inc;
        if (bc_inc == 4'd2) begin
          second_d = n;
        end
        lastp_d = n;
        if (bc_inc >= eff) begin
          ev_o.wd_v       = 1'b1;
          ev_o.wd_early   = !long_d;
          ev_o.wd.kind    = spisd_pkg::KIND_DATA;
          ev_o.wd.w.mosi  = mo_d;
          ev_o.wd.w.miso  = mi_d;
          ev_o.wd.w.start = OutW'(first_d - IndexBits'(1));
          ev_o.wd.w.span  = OutW'(n - first_d + IndexBits'(2));
          bc_d = '0;
          mo_d = '0;
          mi_d = '0;
        end
      end
    end

    if (smp_i.capture_end) begin
      if (open_f || cont) begin
        ev_o.fin_v = long_d && (!ok_d || (bc_d >= 4'd2 && bc_d < eff));
        ev_o.fin   = close_rec(ok_d, fstart_d, second_d, lastp_d, n);
        infr_d     = 1'b0;
      end
      cnt_d = '0;
    end else begin
      cnt_d = n + IndexBits'(1);
    end

    // any frame open or close empties the held word list
    ev_o.clr = pre_close || open_f || (smp_i.capture_end && (open_f || cont));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      fstart_q <= '0;
      first_q  <= '0;
      second_q <= '0;
      lastp_q  <= '0;
      prev_q   <= 1'b0;
      infr_q   <= 1'b0;
      ok_q     <= 1'b0;
      long_q   <= 1'b0;
      mo_q     <= '0;
      mi_q     <= '0;
      bc_q     <= '0;
    end else if (accept_i) begin
      cnt_q    <= cnt_d;
      fstart_q <= fstart_d;
      first_q  <= first_d;
      second_q <= second_d;
      lastp_q  <= lastp_d;
      prev_q   <= prev_d;
      infr_q   <= infr_d;
      ok_q     <= ok_d;
      long_q   <= long_d;
      mo_q     <= mo_d;
      mi_q     <= mi_d;
      bc_q     <= bc_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/spisd_evq.sv
// short event queue between front and back end
`default_nettype none

module spisd_evq (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire spisd_pkg::event_t data_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output spisd_pkg::event_t      data_o,
  output logic                   empty_o
);

  localparam int Depth = spisd_pkg::EVQ_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  spisd_pkg::event_t slot_q [Depth];
  logic [PtrW-1:0]   wptr_q, rptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/spisd_back.sv
// back end: held word list, record sequencing and output register
`default_nettype none

module spisd_back #(
  parameter int PendDepth = spisd_pkg::PENDING_DEPTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              ev_empty_i,
  input  wire spisd_pkg::event_t ev_i,
  output logic                   ev_pop_o,
  output spisd_pkg::res_t        res_o,
  output logic                   empty,
  input  wire logic              pop
);

  localparam int AddrW = $clog2(PendDepth);
  localparam int CntW  = $clog2(PendDepth + 1);
  localparam int WordW = $bits(spisd_pkg::word_t);

  spisd_pkg::event_t cur_q, cur_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   rem_q, rem_d;
  logic [AddrW-1:0]  ridx_q, ridx_d;
  logic              rdv_q, rdv_d;
  logic              out_vld_q, out_vld_d;
  spisd_pkg::res_t   out_q, out_d;

  spisd_pkg::rec_t   cand;
  spisd_pkg::word_t  rdata;
  logic              cand_v, cand_last, out_free, fl_act, busy, emit, cur_done;
  logic              rd_issue, wr_en;
  logic [WordW-1:0]  rdata_raw;

  spisd_ram #(
    .Width (WordW),
    .Depth (PendDepth)
  ) u_pend (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (cnt_q[AddrW-1:0]),
    .wdata_i (ev_i.wd.w),
    .re_i    (rd_issue),
    .raddr_i (ridx_q),
    .rdata_o (rdata_raw)
  );

  assign rdata    = spisd_pkg::word_t'(rdata_raw);
  assign out_free = !out_vld_q || pop;
  assign fl_act   = (rem_q != '0) || rdv_q;
  assign busy     = cur_q.pre_v || fl_act || cur_q.wd_v || cur_q.fin_v;
  assign rd_issue = !cur_q.pre_v && (rem_q != '0) && (!rdv_q || out_free);

  // next record of the current event, in emission order
  always_comb begin
    cand      = '0;
    cand_v    = 1'b0;
    cand_last = 1'b0;
    priority if (cur_q.pre_v) begin
      cand      = cur_q.pre;
      cand_v    = 1'b1;
      cand_last = (rem_q == '0) && !cur_q.wd_v && !cur_q.fin_v;
    end else if (fl_act) begin
      cand.kind = spisd_pkg::KIND_DATA;
      cand.w    = rdata;
      cand_v    = rdv_q;
      cand_last = (rem_q == '0) && !cur_q.wd_v && !cur_q.fin_v;
    end else if (cur_q.wd_v) begin
      cand      = cur_q.wd;
      cand_v    = 1'b1;
      cand_last = !cur_q.fin_v;
    end else if (cur_q.fin_v) begin
      cand      = cur_q.fin;
      cand_v    = 1'b1;
      cand_last = 1'b1;
    end else begin
      cand_v = 1'b0;
    end
  end

  assign emit     = cand_v && out_free;
  assign cur_done = !busy || (emit && cand_last);
  assign ev_pop_o = cur_done && !ev_empty_i;
  assign wr_en    = ev_pop_o && ev_i.wd_v && ev_i.wd_early && (cnt_q < CntW'(PendDepth));

  always_comb begin
    cur_d     = cur_q;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    ridx_d    = ridx_q;
    rdv_d     = rdv_q;
    out_vld_d = out_vld_q;
    out_d     = out_q;

    if (emit) begin
      out_vld_d               = 1'b1;
      out_d.record_kind       = cand.kind;
      out_d.mosi_word         = cand.w.mosi;
      out_d.miso_word         = cand.w.miso;
      out_d.start_sample      = cand.w.start;
      out_d.span_samples      = cand.w.span;
      out_d.last_of_run       = cand_last;
      priority if (cur_q.pre_v) begin
        cur_d.pre_v = 1'b0;
      end else if (fl_act) begin
        rdv_d = 1'b0;
      end else if (cur_q.wd_v) begin
        cur_d.wd_v = 1'b0;
      end else begin
        cur_d.fin_v = 1'b0;
      end
    end else if (pop) begin
      out_vld_d = 1'b0;
    end

    if (rd_issue) begin
      rem_d  = rem_q - CntW'(1);
      ridx_d = ridx_q + AddrW'(1);
      rdv_d  = 1'b1;
    end

    if (cur_done) begin
      if (ev_pop_o) begin
        cur_d      = ev_i;
        // early words go to the held list while it has room, not out
        cur_d.wd_v = ev_i.wd_v && !ev_i.wd_early;
        rem_d      = ev_i.flush ? cnt_q : '0;
        ridx_d     = '0;
        rdv_d      = 1'b0;
        if (ev_i.clr || ev_i.flush) begin
          cnt_d = '0;
        end else if (wr_en) begin
          cnt_d = cnt_q + CntW'(1);
        end
      end else begin
        cur_d.pre_v = 1'b0;
        cur_d.wd_v  = 1'b0;
        cur_d.fin_v = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q     <= '0;
      cnt_q     <= '0;
      rem_q     <= '0;
      ridx_q    <= '0;
      rdv_q     <= 1'b0;
      out_vld_q <= 1'b0;
      out_q     <= '0;
    end else begin
      cur_q     <= cur_d;
      cnt_q     <= cnt_d;
      rem_q     <= rem_d;
      ridx_q    <= ridx_d;
      rdv_q     <= rdv_d;
      out_vld_q <= out_vld_d;
      out_q     <= out_d;
    end
  end

  assign empty = !out_vld_q;
  assign res_o = out_q;

endmodule

`default_nettype wire
